// ----- rtl/vaxm_pkg.sv -----
// Shared types, constants and helper functions for the vec4 ALU with matrix transform.
`timescale 1ns / 1ps
package vaxm_pkg;

  localparam int COMP_W      = 16;
  localparam int FRAC_BITS   = 8;
  localparam int LANES       = 4;
  localparam int SQRT_STAGES = 17;
  localparam int DIV_STAGES  = 24;
  localparam int RAD_W       = 34;
  localparam int LEN_W       = 17;
  localparam int NUM_W       = COMP_W + FRAC_BITS;
  localparam logic signed [COMP_W-1:0] ONE_Q = 16'sh0100;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_NEG  = 4'd2,
    OP_SCL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_DOT3 = 4'd5,
    OP_XFRM = 4'd6,
    OP_LEN  = 4'd7,
    OP_NORM = 4'd8,
    OP_LERP = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    REG_ROW0 = 4'd0,
    REG_ROW1 = 4'd1,
    REG_ROW2 = 4'd2,
    REG_ROW3 = 4'd3
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [COMP_W-1:0] a_x;
    logic signed [COMP_W-1:0] a_y;
    logic signed [COMP_W-1:0] a_z;
    logic signed [COMP_W-1:0] a_w;
    logic signed [COMP_W-1:0] b_x;
    logic signed [COMP_W-1:0] b_y;
    logic signed [COMP_W-1:0] b_z;
    logic signed [COMP_W-1:0] b_w;
    logic signed [COMP_W-1:0] scalar_in;
  } cmd_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic signed [COMP_W-1:0] scalar_out;
    logic                     divide_by_zero;
    logic                     saturated;
  } result_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] v;
    logic                     sat;
  } clamp_t;

  typedef struct packed {
    logic [3:0]                  op;
    clamp_t [LANES-1:0]          lane;
    clamp_t                      dot;
    logic [LANES-1:0][NUM_W-1:0] nmag;
    logic [LANES-1:0]            aneg;
    logic                        sneg;
    logic [COMP_W-1:0]           smag;
  } side_t;

  function automatic clamp_t clamp36(input logic signed [35:0] x);
    clamp_t r;
    if (x > 36'sd32767) begin
      r.v   = 16'sh7fff;
      r.sat = 1'b1;
    end else if (x < -36'sd32768) begin
      r.v   = 16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.v   = x[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] mag16(input logic signed [COMP_W-1:0] x);
    return x[COMP_W-1] ? (~x + 16'd1) : x;
  endfunction

endpackage

// ----- rtl/vec4_alu_with_matrix_transform.sv -----
// Top level: four component lanes, shared square root, four dividers, merge stage.
//
//   channel  | signals                                   | direction
//   command  | start, busy, cmd                          | in
//   result   | result_valid, result                      | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Takes one command word every cycle; busy stays low.
// Each result passes through the 17-stage square root feeding the
// 24-stage dividers before it leaves.
// rst (synchronous) clears the pipeline valid bits and the matrix rows.
// Results are shown for one cycle with result_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module vec4_alu_with_matrix_transform (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  vaxm_pkg::cmd_word_t     cmd,
  output logic                    result_valid,
  output vaxm_pkg::result_word_t  result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [3:0]              cfg_index,
  input  logic [63:0]             cfg_data
);
  import vaxm_pkg::*;

  localparam int TOTAL = 4 + SQRT_STAGES + DIV_STAGES;
  localparam int SIDE_D = SQRT_STAGES + DIV_STAGES;

  logic [63:0]                  row [4];
  logic [TOTAL-1:0]             vld;
  cmd_word_t                    c1;
  logic [3:0][COMP_W-1:0]       av1, bv1;
  logic signed [2*COMP_W-1:0]   ab2 [LANES];
  logic signed [2*COMP_W-1:0]   aa2 [LANES];
  clamp_t                       lres3 [LANES];
  logic [3:0]                   op2;
  logic [3:0][COMP_W-1:0]       a2;
  logic signed [COMP_W-1:0]     s2;
  side_t                        side3;
  side_t                        side_next;
  side_t                        side_line_in;
  logic [RAD_W-1:0]             rad3;
  logic [RAD_W-1:0]             rad_next;
  side_t                        side_line [SIDE_D];
  logic [LEN_W-1:0]             len;
  logic [LEN_W-1:0]             len_line [DIV_STAGES];
  logic [LEN_W-1:0]             den;
  logic [NUM_W-1:0]             quo [LANES];
  side_t                        so;
  logic [LEN_W-1:0]             lo;
  result_word_t                 result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        row[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0: row[0] <= cfg_data;
        REG_ROW1: row[1] <= cfg_data;
        REG_ROW2: row[2] <= cfg_data;
        REG_ROW3: row[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      c1 <= cmd;
    end
  end

  assign av1 = {c1.a_w, c1.a_z, c1.a_y, c1.a_x};
  assign bv1 = {c1.b_w, c1.b_z, c1.b_y, c1.b_x};

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [3:0][COMP_W-1:0] mcol;
    for (genvar k = 0; k < 4; k++) begin : g_coef
      assign mcol[k] = row[k][COMP_W*j +: COMP_W];
    end
    vaxm_lane u_lane (
      .clk  (clk),
      .op   (c1.opcode),
      .a    ($signed(av1[j])),
      .b    ($signed(bv1[j])),
      .s    (c1.scalar_in),
      .avec (av1),
      .mcol (mcol),
      .ab   (ab2[j]),
      .aa   (aa2[j]),
      .res  (lres3[j])
    );
  end

  always_ff @(posedge clk) begin
    op2 <= c1.opcode;
    a2  <= av1;
    s2  <= c1.scalar_in;
  end

  always_comb begin
    logic signed [2*COMP_W+1:0] dsum;
    dsum = 34'(ab2[0]) + 34'(ab2[1]) + 34'(ab2[2]);
    side_next      = '0;
    side_next.op   = op2;
    side_next.dot  = clamp36(36'(dsum >>> FRAC_BITS));
    side_next.sneg = s2[COMP_W-1];
    side_next.smag = mag16(s2);
    rad_next       = '0;
    for (int i = 0; i < LANES; i++) begin
      side_next.aneg[i] = a2[i][COMP_W-1];
      side_next.nmag[i] = {mag16($signed(a2[i])), {FRAC_BITS{1'b0}}};
      rad_next          = rad_next + RAD_W'($unsigned(aa2[i]));
    end
  end

  always_ff @(posedge clk) begin
    side3 <= side_next;
    rad3  <= rad_next;
  end

  always_comb begin
    side_t s3;
    s3 = side3;
    for (int i = 0; i < LANES; i++) begin
      s3.lane[i] = lres3[i];
    end
    side_line_in = s3;
  end

  always_ff @(posedge clk) begin
    side_line[0] <= side_line_in;
    for (int k = 1; k < SIDE_D; k++) begin
      side_line[k] <= side_line[k-1];
    end
  end

  vaxm_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad3),
    .root (len)
  );

  always_comb begin
    side_t sd;
    sd = side_line[SQRT_STAGES-1];
    den = (op_t'(sd.op) == OP_DIV) ? {1'b0, sd.smag} : len;
    if (den == '0) begin
      den = LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    len_line[0] <= len;
    for (int k = 1; k < DIV_STAGES; k++) begin
      len_line[k] <= len_line[k-1];
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_div
    vaxm_div u_div (
      .clk (clk),
      .num (side_line[SQRT_STAGES-1].nmag[j]),
      .den (den),
      .quo (quo[j])
    );
  end

  assign so = side_line[SIDE_D-1];
  assign lo = len_line[DIV_STAGES-1];

  always_comb begin
    logic signed [35:0] qv;
    logic               neg;
    clamp_t             cv [LANES];
    logic               sat;
    result_word_t       r;
    r   = '0;
    sat = 1'b0;
    qv  = '0;
    neg = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      cv[i] = '0;
    end
    case (op_t'(so.op))
      OP_ADD, OP_SUB, OP_NEG, OP_SCL, OP_XFRM, OP_LERP: begin
        for (int i = 0; i < LANES; i++) begin
          cv[i] = so.lane[i];
          sat   = sat | so.lane[i].sat;
        end
      end
      OP_DIV, OP_NORM: begin
        if ((op_t'(so.op) == OP_DIV && so.smag == '0) ||
            (op_t'(so.op) == OP_NORM && lo == '0)) begin
          r.divide_by_zero = 1'b1;
        end else begin
          for (int i = 0; i < LANES; i++) begin
            neg   = so.aneg[i] ^ ((op_t'(so.op) == OP_DIV) & so.sneg);
            qv    = $signed({12'b0, quo[i]});
            cv[i] = clamp36(neg ? -qv : qv);
            sat   = sat | cv[i].sat;
          end
        end
      end
      OP_DOT3: begin
        r.scalar_out = so.dot.v;
        sat          = so.dot.sat;
      end
      OP_LEN: begin
        cv[0]        = clamp36(36'({19'b0, lo}));
        r.scalar_out = cv[0].v;
        sat          = cv[0].sat;
        cv[0]        = '0;
      end
      default: ;
    endcase
    r.out_x     = cv[0].v;
    r.out_y     = cv[1].v;
    r.out_z     = cv[2].v;
    r.out_w     = cv[3].v;
    r.saturated = sat;
    result_next = r;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  assign result_valid = vld[TOTAL-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##TOTAL result_valid)
    else $error("result strobe missing after command");
  a_dz_nosat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.divide_by_zero |-> !result.saturated)
    else $error("divide by zero with saturation");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.divide_by_zero |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0 &&
      result.out_w == '0 && result.scalar_out == '0)
    else $error("divide by zero with nonzero result");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(vld[TOTAL-2]))
    else $error("result strobe without command");
`endif

endmodule

// ----- rtl/vaxm_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps
module vaxm_sqrt (
  input  logic                       clk,
  input  logic [vaxm_pkg::RAD_W-1:0] rad,
  output logic [vaxm_pkg::LEN_W-1:0] root
);
  import vaxm_pkg::*;

  logic [LEN_W:0]   rem_q  [SQRT_STAGES];
  logic [LEN_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0] rad_q  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [LEN_W:0]   rem_i;
    logic [LEN_W-1:0] root_i;
    logic [RAD_W-1:0] rad_i;
    logic [LEN_W+2:0] rem_t;
    logic [LEN_W+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    assign rem_t = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      rad_q[k] <= {rad_i[RAD_W-3:0], 2'b00};
      if (rem_t >= (LEN_W+3)'(trial)) begin
        rem_q[k]  <= (LEN_W+1)'(rem_t - (LEN_W+3)'(trial));
        root_q[k] <= {root_i[LEN_W-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_t[LEN_W:0];
        root_q[k] <= {root_i[LEN_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

// ----- rtl/vaxm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vaxm_div (
  input  logic                       clk,
  input  logic [vaxm_pkg::NUM_W-1:0] num,
  input  logic [vaxm_pkg::LEN_W-1:0] den,
  output logic [vaxm_pkg::NUM_W-1:0] quo
);
  import vaxm_pkg::*;

  logic [NUM_W-1:0] n_q [DIV_STAGES];
  logic [LEN_W-1:0] r_q [DIV_STAGES];
  logic [LEN_W-1:0] d_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [NUM_W-1:0] n_i;
    logic [LEN_W-1:0] r_i;
    logic [LEN_W-1:0] d_i;
    logic [LEN_W:0]   rem_t;

    if (k == 0) begin : g_first
      assign n_i = num;
      assign r_i = '0;
      assign d_i = den;
    end else begin : g_next
      assign n_i = n_q[k-1];
      assign r_i = r_q[k-1];
      assign d_i = d_q[k-1];
    end

    assign rem_t = {r_i, n_i[NUM_W-1]};

    always_ff @(posedge clk) begin
      d_q[k] <= d_i;
      if (rem_t >= {1'b0, d_i}) begin
        r_q[k] <= LEN_W'(rem_t - {1'b0, d_i});
        n_q[k] <= {n_i[NUM_W-2:0], 1'b1};
      end else begin
        r_q[k] <= rem_t[LEN_W-1:0];
        n_q[k] <= {n_i[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = n_q[DIV_STAGES-1];

endmodule

// ----- rtl/vaxm_lane.sv -----
// One component lane: products, then add/sub/negate/scale/lerp/transform column.
`timescale 1ns / 1ps
module vaxm_lane (
  input  logic                             clk,
  input  logic [3:0]                       op,
  input  logic signed [vaxm_pkg::COMP_W-1:0] a,
  input  logic signed [vaxm_pkg::COMP_W-1:0] b,
  input  logic signed [vaxm_pkg::COMP_W-1:0] s,
  input  logic [3:0][vaxm_pkg::COMP_W-1:0] avec,
  input  logic [3:0][vaxm_pkg::COMP_W-1:0] mcol,
  output logic signed [2*vaxm_pkg::COMP_W-1:0] ab,
  output logic signed [2*vaxm_pkg::COMP_W-1:0] aa,
  output vaxm_pkg::clamp_t                 res
);
  import vaxm_pkg::*;

  logic [3:0]                 op2;
  logic signed [COMP_W-1:0]   a2, b2, s2;
  logic signed [2*COMP_W-1:0] scp;
  logic signed [2*COMP_W:0]   lpp;
  logic signed [2*COMP_W-1:0] tp [4];
  logic signed [COMP_W:0]     diff;
  logic signed [2*COMP_W+1:0] tsum;
  clamp_t                     res_next;

  assign diff = 17'(b) - 17'(a);

  always_ff @(posedge clk) begin
    op2 <= op;
    a2  <= a;
    b2  <= b;
    s2  <= s;
    scp <= a * s;
    lpp <= diff * 17'(s);
    ab  <= a * b;
    aa  <= a * a;
    for (int k = 0; k < 4; k++) begin
      tp[k] <= $signed(avec[k]) * $signed(mcol[k]);
    end
  end

  assign tsum = 34'(tp[0]) + 34'(tp[1]) + 34'(tp[2]) + 34'(tp[3]);

  always_comb begin
    res_next = '0;
    case (op_t'(op2))
      OP_ADD:  res_next = clamp36(36'(a2) + 36'(b2));
      OP_SUB:  res_next = clamp36(36'(a2) - 36'(b2));
      OP_NEG:  res_next = clamp36(-36'(a2));
      OP_SCL:  res_next = clamp36(36'(scp >>> FRAC_BITS));
      OP_XFRM: res_next = clamp36(36'(tsum >>> FRAC_BITS));
      OP_LERP: begin
        if (s2 <= 16'sd0) begin
          res_next.v = a2;
        end else if (s2 >= ONE_Q) begin
          res_next.v = b2;
        end else begin
          res_next = clamp36(36'(a2) + 36'(lpp >>> FRAC_BITS));
        end
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ----- test/vec4_alu_with_matrix_transform_tb.sv -----
// Self-checking testbench for the vec4 ALU with matrix transform: directed table, random words.
`timescale 1ns / 1ps
module vec4_alu_with_matrix_transform_tb;
  import vaxm_pkg::*;

  localparam logic [3:0]  OP_UNUSED = 4'd15;
  localparam logic [15:0] MAXV = 16'h7fff;
  localparam logic [15:0] MINV = 16'h8000;
  localparam logic [15:0] ZERO = 16'h0000;
  localparam int DRAIN = 60;

  typedef struct {
    cmd_word_t    c;
    bit           known;
    result_word_t r;
  } vec_row_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  cmd_word_t    cmd;
  logic         result_valid;
  result_word_t result;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [3:0]   cfg_index;
  logic [63:0]  cfg_data;

  logic [63:0]  matrix [4];
  result_word_t pending_results [$];
  vec_row_t     directed [$];
  bit           failed;

  vec4_alu_with_matrix_transform dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint clip(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint floor_root(input longint n);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_word_t alu_result(input cmd_word_t c);
    longint a [4];
    longint b [4];
    longint v [4];
    longint s;
    longint sc;
    longint acc;
    longint len;
    bit sat;
    bit dz;
    result_word_t r;
    a[0] = c.a_x; a[1] = c.a_y; a[2] = c.a_z; a[3] = c.a_w;
    b[0] = c.b_x; b[1] = c.b_y; b[2] = c.b_z; b[3] = c.b_w;
    s = c.scalar_in;
    sc = 0;
    sat = 1'b0;
    dz = 1'b0;
    for (int i = 0; i < 4; i++) v[i] = 0;
    case (c.opcode)
      OP_ADD: for (int i = 0; i < 4; i++) v[i] = clip(a[i] + b[i], sat);
      OP_SUB: for (int i = 0; i < 4; i++) v[i] = clip(a[i] - b[i], sat);
      OP_NEG: for (int i = 0; i < 4; i++) v[i] = clip(-a[i], sat);
      OP_SCL: for (int i = 0; i < 4; i++) v[i] = clip((a[i] * s) >>> FRAC_BITS, sat);
      OP_DIV: begin
        if (s == 0) dz = 1'b1;
        else for (int i = 0; i < 4; i++) v[i] = clip((a[i] * 256) / s, sat);
      end
      OP_DOT3: sc = clip((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC_BITS, sat);
      OP_XFRM: begin
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int i = 0; i < 4; i++)
            acc = acc + a[i] * longint'($signed(matrix[i][16*j +: 16]));
          v[j] = clip(acc >>> FRAC_BITS, sat);
        end
      end
      OP_LEN, OP_NORM: begin
        len = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
        if (c.opcode == OP_LEN) sc = clip(len, sat);
        else if (len == 0) dz = 1'b1;
        else for (int i = 0; i < 4; i++) v[i] = clip((a[i] * 256) / len, sat);
      end
      OP_LERP: begin
        for (int i = 0; i < 4; i++) begin
          if (s <= 0) v[i] = a[i];
          else if (s >= 256) v[i] = b[i];
          else v[i] = clip(a[i] + (((b[i] - a[i]) * s) >>> FRAC_BITS), sat);
        end
      end
      default: ;
    endcase
    r.out_x = 16'(v[0]);
    r.out_y = 16'(v[1]);
    r.out_z = 16'(v[2]);
    r.out_w = 16'(v[3]);
    r.scalar_out = 16'(sc);
    r.divide_by_zero = dz;
    r.saturated = sat;
    return r;
  endfunction

  function automatic cmd_word_t mk(input logic [3:0] op, input logic [15:0] ax, ay, az, aw,
                                   input logic [15:0] bx, by, bz, bw, s);
    cmd_word_t c;
    c.opcode = op;
    c.a_x = ax; c.a_y = ay; c.a_z = az; c.a_w = aw;
    c.b_x = bx; c.b_y = by; c.b_z = bz; c.b_w = bw;
    c.scalar_in = s;
    return c;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 1023) - 512);
      1: begin
        case ($urandom_range(0, 3))
          0: return MAXV;
          1: return MINV;
          2: return ZERO;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_word_t rand_cmd();
    cmd_word_t c;
    logic [3:0] op;
    logic [15:0] s;
    op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    s = rand_comp();
    if (op == OP_LERP && $urandom_range(0, 1)) s = 16'($urandom_range(0, 256));
    if (op == OP_DIV && $urandom_range(0, 9) == 0) s = ZERO;
    c = mk(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
           rand_comp(), rand_comp(), rand_comp(), rand_comp(), s);
    if (op == OP_NORM && $urandom_range(0, 9) == 0) begin
      c.a_x = ZERO; c.a_y = ZERO; c.a_z = ZERO; c.a_w = ZERO;
    end
    return c;
  endfunction

  task automatic send(input cmd_word_t c, input result_word_t exp_r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(exp_r);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_ROW3) matrix[idx] = data;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_word_t e;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (result.out_x !== e.out_x) begin
          $error("out_x expected %0d got %0d", e.out_x, result.out_x);
          failed = 1'b1;
        end
        if (result.out_y !== e.out_y) begin
          $error("out_y expected %0d got %0d", e.out_y, result.out_y);
          failed = 1'b1;
        end
        if (result.out_z !== e.out_z) begin
          $error("out_z expected %0d got %0d", e.out_z, result.out_z);
          failed = 1'b1;
        end
        if (result.out_w !== e.out_w) begin
          $error("out_w expected %0d got %0d", e.out_w, result.out_w);
          failed = 1'b1;
        end
        if (result.scalar_out !== e.scalar_out) begin
          $error("scalar_out expected %0d got %0d", e.scalar_out, result.scalar_out);
          failed = 1'b1;
        end
        if (result.divide_by_zero !== e.divide_by_zero) begin
          $error("divide_by_zero expected %0d got %0d", e.divide_by_zero, result.divide_by_zero);
          failed = 1'b1;
        end
        if (result.saturated !== e.saturated) begin
          $error("saturated expected %0d got %0d", e.saturated, result.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("[vec4_alu_with_matrix_transform] ERROR");
    $finish;
  end

  initial begin
    logic [63:0] ident [4];
    int gap;
    failed = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) matrix[i] = '0;
    ident[0] = 64'h0000_0000_0000_0100;
    ident[1] = 64'h0000_0000_0100_0000;
    ident[2] = 64'h0000_0100_0000_0000;
    ident[3] = 64'h0100_0000_0000_0000;

    directed.push_back('{mk(OP_ADD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, ZERO),
                         1'b1, '{MAXV, MAXV, MAXV, MAXV, ZERO, 1'b0, 1'b1}});
    directed.push_back('{mk(OP_ADD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, ZERO),
                         1'b1, '{MINV, MINV, MINV, MINV, ZERO, 1'b0, 1'b1}});
    directed.push_back('{mk(OP_SUB, MAXV, MINV, ZERO, 16'h0100, MINV, MAXV, ZERO, 16'h0080, MAXV),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_NEG, MINV, MINV, MINV, MINV, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b1, '{MAXV, MAXV, MAXV, MAXV, ZERO, 1'b0, 1'b1}});
    directed.push_back('{mk(OP_NEG, MAXV, ZERO, 16'hffff, 16'h0001, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_SCL, MAXV, MINV, 16'h0180, 16'hff00, ZERO, ZERO, ZERO, ZERO, MINV),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_SCL, 16'h0101, 16'hfeff, 16'h0001, 16'hffff, ZERO, ZERO, ZERO, ZERO,
                            16'h0080), 1'b0, '{default: '0}});
    directed.push_back('{mk(OP_DIV, MAXV, MINV, 16'h0100, 16'hffff, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 1'b0}});
    directed.push_back('{mk(OP_DIV, MAXV, MINV, 16'h0100, 16'hffff, ZERO, ZERO, ZERO, ZERO,
                            16'hffff), 1'b0, '{default: '0}});
    directed.push_back('{mk(OP_DIV, 16'h0300, 16'hfd00, 16'h0001, 16'hffff, ZERO, ZERO, ZERO, ZERO,
                            16'h0200), 1'b0, '{default: '0}});
    directed.push_back('{mk(OP_DOT3, MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, ZERO),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, MAXV, 1'b0, 1'b1}});
    directed.push_back('{mk(OP_DOT3, 16'h0100, 16'h0200, 16'hff00, MAXV, 16'h0100, 16'h0080,
                            16'h0100, MAXV, ZERO), 1'b0, '{default: '0}});
    directed.push_back('{mk(OP_XFRM, MAXV, MINV, MAXV, MINV, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0}});
    directed.push_back('{mk(OP_LEN, MINV, MINV, MINV, MINV, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, MAXV, 1'b0, 1'b1}});
    directed.push_back('{mk(OP_LEN, 16'h0300, 16'h0400, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_NORM, ZERO, ZERO, ZERO, ZERO, MAXV, MAXV, MAXV, MAXV, MAXV),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, ZERO, 1'b1, 1'b0}});
    directed.push_back('{mk(OP_NORM, 16'h0001, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_NORM, MINV, 16'h0300, 16'hfc00, MAXV, ZERO, ZERO, ZERO, ZERO, ZERO),
                         1'b0, '{default: '0}});
    directed.push_back('{mk(OP_LERP, MAXV, MINV, 16'h0100, ZERO, MINV, MAXV, ZERO, 16'h0100, MINV),
                         1'b1, '{MAXV, MINV, 16'h0100, ZERO, ZERO, 1'b0, 1'b0}});
    directed.push_back('{mk(OP_LERP, MAXV, MINV, 16'h0100, ZERO, MINV, MAXV, ZERO, 16'h0100,
                            16'h0100), 1'b1, '{MINV, MAXV, ZERO, 16'h0100, ZERO, 1'b0, 1'b0}});
    directed.push_back('{mk(OP_LERP, MINV, MAXV, 16'h0000, 16'h0100, MAXV, MINV, 16'h0100, ZERO,
                            16'h0080), 1'b0, '{default: '0}});
    directed.push_back('{mk(OP_UNUSED, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV),
                         1'b1, '{ZERO, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0}});
    directed.push_back('{mk(4'(OP_LERP + 1), MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV,
                            MINV), 1'b1, '{ZERO, ZERO, ZERO, ZERO, ZERO, 1'b0, 1'b0}});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      gap = (k % 2 == 0) ? 0 : $urandom_range(0, 18);
      send(directed[k].c, directed[k].known ? directed[k].r : alu_result(directed[k].c), gap);
    end
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 4; r++) begin
        case (ph)
          0: write_reg(4'(r), ident[r]);
          1: write_reg(4'(r), {4{MAXV}});
          2: write_reg(4'(r), {4{MINV}});
          3: write_reg(4'(r), 64'({$urandom, $urandom}));
          default: write_reg(4'(r), {4{16'($urandom_range(0, 1023) - 512)}});
        endcase
      end
      write_reg(4'($urandom_range(4, 15)), 64'({$urandom, $urandom}));
      cfg_valid <= 1'b0;
      for (int k = 0; k < 100; k++) begin
        cmd_word_t c;
        c = rand_cmd();
        gap = (k % 40 < 12) ? 0 : $urandom_range(0, 18);
        send(c, alu_result(c), gap);
      end
      drain();
    end

    if (failed) begin
      $display("[vec4_alu_with_matrix_transform] ERROR");
    end else begin
      $display("[vec4_alu_with_matrix_transform] OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vaxm_pkg.sv
rtl/vaxm_sqrt.sv
rtl/vaxm_div.sv
rtl/vaxm_lane.sv
rtl/vec4_alu_with_matrix_transform.sv
test/vec4_alu_with_matrix_transform_tb.sv
